### design/kwms_pkg.sv
// ----------------------------------------------------------------------------
// kwms_pkg: shared types and constants of the k-mer minimizer sampler
// Widths of the stream fields, register map codes, the controller state
// encoding and the comparison flags that each window cell reports.
// ----------------------------------------------------------------------------
package kwms_pkg;

	localparam int KMER_W = 64;
	localparam int POS_W  = 32;
	localparam int SEQ_W  = 32;
	localparam int WLEN_W = 5;
	localparam int APB_DW = 32;
	localparam int ADDR_W = 3;

	localparam logic [KMER_W-1:0] ALL_ONES    = '1;
	localparam logic [WLEN_W-1:0] WLEN_RESET  = WLEN_W'(10);

	// Register index codes, decoded from paddr[2].
	localparam logic REG_WINDOW_LENGTH   = 1'b0;
	localparam logic REG_SEQUENCE_NUMBER = 1'b1;

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_FILL    = 6'b000010,
		ST_RESCAN  = 6'b000100,
		ST_RESEMIT = 6'b001000,
		ST_ENDSCAN = 6'b010000,
		ST_FLUSH   = 6'b100000
	} state_t;

	typedef struct packed {
		logic le;
		logic eq;
	} cell_cmp_t;

	typedef struct packed {
		logic [KMER_W-1:0] value;
		logic [POS_W-1:0]  position;
	} result_t;

endpackage

### design/kwms_if.sv
// ----------------------------------------------------------------------------
// kwms_if: stream channels of the k-mer minimizer sampler
// One channel carries k-mers into the block, the other carries minimizers
// out; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface kwms_kmer_if;
	import kwms_pkg::*;

	logic              valid;
	logic              ready;
	logic [KMER_W-1:0] kmer_value;
	logic              end_of_sequence;

	modport source (output valid, output kmer_value, output end_of_sequence, input ready);
	modport sink   (input valid, input kmer_value, input end_of_sequence, output ready);
endinterface

interface kwms_mini_if;
	import kwms_pkg::*;

	logic              valid;
	logic              ready;
	logic [KMER_W-1:0] minimizer_value;
	logic [POS_W-1:0]  minimizer_pos;
	logic [SEQ_W-1:0]  seq_ident;
	logic              last_of_run;

	modport source (output valid, output minimizer_value, output minimizer_pos,
		output seq_ident, output last_of_run, input ready);
	modport sink   (input valid, input minimizer_value, input minimizer_pos,
		input seq_ident, input last_of_run, output ready);
endinterface

### design/kwms_cell.sv
// ----------------------------------------------------------------------------
// kwms_cell: one window cell
// Holds one k-mer, takes its neighbour's k-mer on every shift and compares
// its own k-mer against the value broadcast along the row.
// ----------------------------------------------------------------------------
module kwms_cell (
	input  logic                        clk,
	input  logic                        shift_en,
	input  logic [kwms_pkg::KMER_W-1:0] din,
	input  logic [kwms_pkg::KMER_W-1:0] probe,
	output logic [kwms_pkg::KMER_W-1:0] dout,
	output kwms_pkg::cell_cmp_t         cmp
);
	import kwms_pkg::*;

	logic [KMER_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			value_q <= din;
		end
	end

	assign dout   = value_q;
	assign cmp.le = (value_q <= probe);
	assign cmp.eq = (value_q == probe);

endmodule

### design/kwms_window.sv
// ----------------------------------------------------------------------------
// kwms_window: row of window cells
// Cell 0 holds the newest k-mer; each shift moves every k-mer one cell
// further back. One cell at a time is selected for the controller.
// ----------------------------------------------------------------------------
module kwms_window #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4
) (
	input  logic                        clk,
	input  logic                        shift_en,
	input  logic [kwms_pkg::KMER_W-1:0] din,
	input  logic [kwms_pkg::KMER_W-1:0] probe,
	input  logic [IDX_W-1:0]            rd_idx,
	output logic [kwms_pkg::KMER_W-1:0] rd_value,
	output kwms_pkg::cell_cmp_t         rd_cmp
);
	import kwms_pkg::*;

	logic [KMER_W-1:0] cell_val [DEPTH];
	cell_cmp_t         cell_cmp [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			kwms_cell u_cell (
				.clk      (clk),
				.shift_en (shift_en),
				.din      (din),
				.probe    (probe),
				.dout     (cell_val[i]),
				.cmp      (cell_cmp[i])
			);
		end else begin : g_body
			kwms_cell u_cell (
				.clk      (clk),
				.shift_en (shift_en),
				.din      (cell_val[i-1]),
				.probe    (probe),
				.dout     (cell_val[i]),
				.cmp      (cell_cmp[i])
			);
		end
	end

	assign rd_value = cell_val[rd_idx];
	assign rd_cmp   = cell_cmp[rd_idx];

endmodule

### design/kmer_window_minimizer_sampler.sv
// ----------------------------------------------------------------------------
// kmer_window_minimizer_sampler: minimizer sampling over a k-mer stream
// Keeps the last window_length k-mers in a row of cells and emits
// (value, position, sequence id) minimizers on a valid/ready channel.
// ----------------------------------------------------------------------------
// One k-mer is taken per transfer and the block works on one k-mer at a time.
// A k-mer that causes no window scan is transferred and then hands off its
// last result, but no hand-off follows while the first window is still
// filling. The window is scanned over its effective length, one cell per cycle,
// through a single read select on the cell row: the k-mer that completes the
// first window scans it once, a k-mer that pushes out the last copy of the
// minimum scans it to find the new minimum and again to emit its copies, and
// the last k-mer of a sequence with a full window adds one more scan. Scans that
// emit and the last result's hand-off also wait on a stalled result channel.
// There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module kmer_window_minimizer_sampler #(
	parameter int MAX_WINDOW = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [kwms_pkg::ADDR_W-1:0] paddr,
	input  logic [kwms_pkg::APB_DW-1:0] pwdata,
	output logic [kwms_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	kwms_kmer_if.sink                   kmers,
	kwms_mini_if.source                 minimizers
);
	import kwms_pkg::*;

	localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);

	state_t             state_q, state_d;
	logic [WLEN_W-1:0]  wl_q;
	logic [SEQ_W-1:0]   seq_q;
	logic [KMER_W-1:0]  min_q, min_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_kept;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [CNT_W-1:0]   fill_q, fill_d;
	logic [POS_W-1:0]   item_pos_q, item_pos_d;
	logic               end_q, end_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	logic [KMER_W-1:0]  run_q, run_d;
	logic               pend_valid_q;
	result_t            pend_q;
	logic               out_valid_q;
	result_t            out_q;
	logic [SEQ_W-1:0]   out_seq_q;
	logic               out_last_q;

	logic [WLEN_W:0]    wl_ext;
	logic [WLEN_W:0]    eff_ext;
	logic [CNT_W-1:0]   eff_w;
	logic [IDX_W-1:0]   last_idx;
	logic [IDX_W-1:0]   rd_idx;
	logic [KMER_W-1:0]  probe;
	logic [KMER_W-1:0]  rd_value;
	cell_cmp_t          rd_cmp;
	logic               accept;
	logic               out_free;
	logic               cfg_wr;
	logic               wlen_wr;
	logic               new_eq;
	logic               new_lt;
	logic               emit_req;
	result_t            emit_res;
	logic               flush_req;
	logic               clear_seq;
	logic               push;
	logic [POS_W-1:0]   back_pos;

	// Window length clamped to the range the cell row supports.
	assign wl_ext = {1'b0, wl_q};
	always_comb begin
		priority if (wl_ext == '0) begin
			eff_ext = (WLEN_W+1)'(1);
		end else if (wl_ext > (WLEN_W+1)'(MAX_WINDOW)) begin
			eff_ext = (WLEN_W+1)'(MAX_WINDOW);
		end else begin
			eff_ext = wl_ext;
		end
	end
	assign eff_w    = CNT_W'(eff_ext);
	assign last_idx = IDX_W'(eff_w - CNT_W'(1));

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite;
	assign wlen_wr  = cfg_wr && (paddr[2] == REG_WINDOW_LENGTH);

	always_comb begin
		unique case (paddr[2])
			REG_WINDOW_LENGTH:   prdata = {{(APB_DW-WLEN_W){1'b0}}, wl_q};
			REG_SEQUENCE_NUMBER: prdata = seq_q;
			default:             prdata = '0;
		endcase
	end

	assign kmers.ready = (state_q == ST_IDLE);
	assign accept      = kmers.valid & kmers.ready;
	assign out_free    = !out_valid_q || minimizers.ready;

	// While idle the oldest cell of the window is selected, so that the
	// k-mer about to leave can be checked against the minimum.
	assign rd_idx = (state_q == ST_IDLE) ? last_idx : idx_q;
	assign probe  = (state_q == ST_FILL || state_q == ST_ENDSCAN) ? run_q : min_q;

	kwms_window #(
		.DEPTH (MAX_WINDOW),
		.IDX_W (IDX_W)
	) u_window (
		.clk      (clk),
		.shift_en (accept),
		.din      (kmers.kmer_value),
		.probe    (probe),
		.rd_idx   (rd_idx),
		.rd_value (rd_value),
		.rd_cmp   (rd_cmp)
	);

	assign new_eq   = (kmers.kmer_value == min_q);
	assign new_lt   = (kmers.kmer_value < min_q);
	assign back_pos = item_pos_q - POS_W'(idx_q);
	assign cnt_kept = rd_cmp.eq ? (cnt_q - CNT_W'(1)) : cnt_q;

	always_comb begin
		state_d    = state_q;
		min_d      = min_q;
		cnt_d      = cnt_q;
		pos_d      = pos_q;
		fill_d     = fill_q;
		item_pos_d = item_pos_q;
		end_d      = end_q;
		idx_d      = idx_q;
		run_d      = run_q;
		emit_req   = 1'b0;
		emit_res   = '{value: rd_value, position: back_pos};
		flush_req  = 1'b0;
		clear_seq  = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					item_pos_d = pos_q;
					pos_d      = pos_q + POS_W'(1);
					end_d      = kmers.end_of_sequence;
					emit_res   = '{value: kmers.kmer_value, position: pos_q};
					if (fill_q < eff_w) begin
						fill_d = fill_q + CNT_W'(1);
						if (new_eq) begin
							cnt_d = cnt_q + CNT_W'(1);
						end else if (new_lt) begin
							min_d = kmers.kmer_value;
							cnt_d = CNT_W'(1);
						end
						if (fill_d >= eff_w) begin
							state_d = ST_FILL;
							idx_d   = last_idx;
							run_d   = ALL_ONES;
						end else if (kmers.end_of_sequence) begin
							clear_seq = 1'b1;
						end
					end else if (rd_cmp.eq && cnt_q <= CNT_W'(1)) begin
						min_d   = ALL_ONES;
						cnt_d   = '0;
						state_d = ST_RESCAN;
						idx_d   = last_idx;
					end else begin
						if (new_eq) begin
							cnt_d    = cnt_kept + CNT_W'(1);
							emit_req = 1'b1;
						end else if (new_lt) begin
							min_d    = kmers.kmer_value;
							cnt_d    = CNT_W'(1);
							emit_req = 1'b1;
						end else begin
							cnt_d = cnt_kept;
						end
						if (kmers.end_of_sequence) begin
							state_d = ST_ENDSCAN;
							idx_d   = '0;
							run_d   = ALL_ONES;
						end else begin
							state_d = ST_FLUSH;
						end
					end
				end
			end
			ST_FILL: begin
				if (out_free) begin
					if (rd_cmp.le) begin
						run_d    = rd_value;
						emit_req = 1'b1;
					end
					if (idx_q == '0) begin
						if (end_q) begin
							state_d = ST_ENDSCAN;
							run_d   = ALL_ONES;
						end else begin
							state_d = ST_FLUSH;
						end
					end else begin
						idx_d = idx_q - IDX_W'(1);
					end
				end
			end
			ST_RESCAN: begin
				if (rd_cmp.le && !rd_cmp.eq) begin
					min_d = rd_value;
					cnt_d = CNT_W'(1);
				end else if (rd_cmp.eq) begin
					cnt_d = cnt_q + CNT_W'(1);
				end
				if (idx_q == '0) begin
					state_d = ST_RESEMIT;
					idx_d   = last_idx;
				end else begin
					idx_d = idx_q - IDX_W'(1);
				end
			end
			ST_RESEMIT: begin
				if (out_free) begin
					emit_req = rd_cmp.eq;
					if (idx_q == '0) begin
						if (end_q) begin
							state_d = ST_ENDSCAN;
							run_d   = ALL_ONES;
						end else begin
							state_d = ST_FLUSH;
						end
					end else begin
						idx_d = idx_q - IDX_W'(1);
					end
				end
			end
			ST_ENDSCAN: begin
				if (out_free) begin
					if (rd_cmp.le) begin
						run_d    = rd_value;
						emit_req = (rd_value > min_q);
					end
					if (idx_q == last_idx) begin
						clear_seq = 1'b1;
						state_d   = ST_FLUSH;
					end else begin
						idx_d = idx_q + IDX_W'(1);
					end
				end
			end
			ST_FLUSH: begin
				if (!pend_valid_q || out_free) begin
					flush_req = pend_valid_q;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (clear_seq || wlen_wr) begin
			min_d  = ALL_ONES;
			cnt_d  = '0;
			pos_d  = '0;
			fill_d = '0;
		end
	end

	// A result waits in the pending register until it is known whether a
	// later result of the same k-mer follows it.
	assign push = (emit_req && pend_valid_q) || flush_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			wl_q         <= WLEN_RESET;
			seq_q        <= '0;
			min_q        <= ALL_ONES;
			cnt_q        <= '0;
			pos_q        <= '0;
			fill_q       <= '0;
			end_q        <= 1'b0;
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			min_q   <= min_d;
			cnt_q   <= cnt_d;
			pos_q   <= pos_d;
			fill_q  <= fill_d;
			end_q   <= end_d;
			idx_q   <= idx_d;
			if (wlen_wr) begin
				wl_q <= pwdata[WLEN_W-1:0];
			end
			if (cfg_wr && paddr[2] == REG_SEQUENCE_NUMBER) begin
				seq_q <= pwdata[SEQ_W-1:0];
			end
			if (emit_req) begin
				pend_valid_q <= 1'b1;
			end else if (flush_req) begin
				pend_valid_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (minimizers.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		item_pos_q <= item_pos_d;
		run_q      <= run_d;
		if (emit_req) begin
			pend_q <= emit_res;
		end
		if (push) begin
			out_q      <= pend_q;
			out_seq_q  <= seq_q;
			out_last_q <= flush_req;
		end
	end

	assign minimizers.valid           = out_valid_q;
	assign minimizers.minimizer_value = out_q.value;
	assign minimizers.minimizer_pos   = out_q.position;
	assign minimizers.seq_ident       = out_seq_q;
	assign minimizers.last_of_run     = out_last_q;

endmodule

### design/kwms_checker.sv
// ----------------------------------------------------------------------------
// kwms_checker: port-level checks of the k-mer minimizer sampler
// Watches the stream channels and the configuration port over time.
// ----------------------------------------------------------------------------
module kwms_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         pready,
	kwms_kmer_if.sink   kmers,
	kwms_mini_if.source minimizers
);
	import kwms_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		minimizers.valid && !minimizers.ready |=>
			minimizers.valid && $stable(minimizers.minimizer_value) &&
			$stable(minimizers.minimizer_pos) && $stable(minimizers.last_of_run))
		else $error("stalled result changed before its transfer");

	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		minimizers.valid && !minimizers.last_of_run |-> !kmers.ready)
		else $error("new k-mer taken while results of the previous one remain");

	a_quiet_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !minimizers.valid)
		else $error("result offered straight after reset");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("configuration port inserted a wait state");

endmodule

bind kmer_window_minimizer_sampler kwms_checker u_kwms_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pready     (pready),
	.kmers      (kmers),
	.minimizers (minimizers)
);

### dv/tb_kmer_window_minimizer_sampler.sv
// ----------------------------------------------------------------------------
// tb_kmer_window_minimizer_sampler: self-checking bench for the minimizer sampler
// K-mer sequences are streamed in over the input channel while the window
// length and sequence id are changed over the register port between phases.
// A behavioural model of the sampler predicts every minimizer at each input
// transfer, and each output transfer is compared field by field in order.
// Both channels idle at random, and the output is held off for a long stretch
// so that the block stalls its input.
// ----------------------------------------------------------------------------
module tb_kmer_window_minimizer_sampler;
	timeunit 1ns;
	timeprecision 1ps;

	import kwms_pkg::*;

	localparam int WIN_DEPTH   = 16;
	localparam int SETTLE      = 4 * WIN_DEPTH;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [KMER_W-1:0] value;
		logic [POS_W-1:0]  position;
		logic [SEQ_W-1:0]  ident;
		logic              last;
	} minimizer_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	kwms_kmer_if kmer_ch ();
	kwms_mini_if mini_ch ();

	kmer_window_minimizer_sampler #(
		.MAX_WINDOW(WIN_DEPTH)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.kmers      (kmer_ch),
		.minimizers (mini_ch)
	);

	// Model state of the sampler.
	logic [KMER_W-1:0] win_q [WIN_DEPTH];
	logic [KMER_W-1:0] run_min;
	int                min_cnt;
	logic [POS_W-1:0]  next_pos;
	int                fill_cnt;
	logic [WLEN_W-1:0] wlen_reg;
	logic [SEQ_W-1:0]  seq_reg;

	minimizer_t expected_minis [$];

	int error_count   = 0;
	int kmers_sent    = 0;
	int seqs_closed   = 0;
	int minis_checked = 0;
	bit source_gaps   = 1'b1;
	bit sink_stalls   = 1'b1;
	bit hold_request  = 1'b0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic void clear_sequence_state();
		foreach (win_q[i]) win_q[i] = '0;
		run_min  = ALL_ONES;
		min_cnt  = 0;
		next_pos = '0;
		fill_cnt = 0;
	endfunction

	function automatic int eff_len();
		if (wlen_reg == 0) return 1;
		if (wlen_reg > WIN_DEPTH) return WIN_DEPTH;
		return int'(wlen_reg);
	endfunction

	function automatic void apply_reg(logic idx, logic [APB_DW-1:0] data);
		if (idx == REG_WINDOW_LENGTH) begin
			wlen_reg = data[WLEN_W-1:0];
			clear_sequence_state();
		end else begin
			seq_reg = data[SEQ_W-1:0];
		end
	endfunction

	function automatic void predict_minimizers(logic [KMER_W-1:0] v, logic eos);
		int                w;
		int                i;
		bit                full;
		bit                rescan;
		logic [POS_W-1:0]  pos;
		logic [KMER_W-1:0] removed;
		logic [KMER_W-1:0] run;
		result_t           found [$];

		w       = eff_len();
		pos     = next_pos;
		removed = win_q[w-1];
		full    = (fill_cnt >= w);
		rescan  = 1'b0;
		for (i = WIN_DEPTH - 1; i > 0; i--) win_q[i] = win_q[i-1];
		win_q[0] = v;
		next_pos = next_pos + 1'b1;

		if (!full) begin
			fill_cnt++;
			if (v == run_min) begin
				min_cnt++;
			end else if (v < run_min) begin
				run_min = v;
				min_cnt = 1;
			end
			if (fill_cnt >= w) begin
				run = ALL_ONES;
				for (i = w - 1; i >= 0; i--) begin
					if (win_q[i] <= run) begin
						run = win_q[i];
						found.insert(found.size(), {win_q[i], POS_W'(pos - POS_W'(i))});
					end
				end
			end
		end else begin
			if (removed == run_min) begin
				if (min_cnt > 0) min_cnt--;
				rescan = (min_cnt == 0);
			end
			if (rescan) begin
				run_min = ALL_ONES;
				for (i = w - 1; i >= 0; i--) begin
					if (win_q[i] == run_min) begin
						min_cnt++;
					end else if (win_q[i] < run_min) begin
						run_min = win_q[i];
						min_cnt = 1;
					end
				end
				for (i = w - 1; i >= 0; i--) begin
					if (win_q[i] == run_min)
						found.insert(found.size(), {run_min, POS_W'(pos - POS_W'(i))});
				end
			end else if (v == run_min) begin
				min_cnt++;
				found.insert(found.size(), {v, pos});
			end else if (v < run_min) begin
				run_min = v;
				min_cnt = 1;
				found.insert(found.size(), {v, pos});
			end
		end

		if (eos) begin
			if (fill_cnt >= w) begin
				run = ALL_ONES;
				for (i = 0; i < w; i++) begin
					if (win_q[i] <= run) begin
						run = win_q[i];
						if (win_q[i] > run_min)
							found.insert(found.size(),
								{win_q[i], POS_W'(pos - POS_W'(i))});
					end
				end
			end
			clear_sequence_state();
		end

		foreach (found[k])
			expected_minis.insert(expected_minis.size(),
				{found[k].value, found[k].position, seq_reg,
				1'(k == found.size() - 1)});
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	function automatic logic [KMER_W-1:0] pick_kmer();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return KMER_W'($urandom_range(0, 7));
		if (r < 80) return {$urandom(), $urandom()};
		if (r < 90) return ($urandom_range(0, 1) != 0) ? ALL_ONES : '0;
		return ALL_ONES - KMER_W'($urandom_range(1, 6));
	endfunction

	// Expected minimizers are worked out at each input transfer.
	always @(posedge clk) begin
		if (arst_n && kmer_ch.valid && kmer_ch.ready)
			predict_minimizers(kmer_ch.kmer_value, kmer_ch.end_of_sequence);
	end

	always @(posedge clk) begin : check_minimizers
		minimizer_t want;
		if (arst_n && mini_ch.valid && mini_ch.ready) begin
			if (expected_minis.size() == 0) begin
				$error("unexpected minimizer %h at position %0d",
					mini_ch.minimizer_value, mini_ch.minimizer_pos);
				error_count++;
			end else begin
				want = expected_minis[0];
				expected_minis.delete(0);
				minis_checked++;
				if (mini_ch.minimizer_value !== want.value) begin
					$error("minimizer_value: expected %h, got %h",
						want.value, mini_ch.minimizer_value);
					error_count++;
				end
				if (mini_ch.minimizer_pos !== want.position) begin
					$error("minimizer_pos: expected %0d, got %0d",
						want.position, mini_ch.minimizer_pos);
					error_count++;
				end
				if (mini_ch.seq_ident !== want.ident) begin
					$error("seq_ident: expected %h, got %h", want.ident, mini_ch.seq_ident);
					error_count++;
				end
				if (mini_ch.last_of_run !== want.last) begin
					$error("last_of_run: expected %b, got %b", want.last, mini_ch.last_of_run);
					error_count++;
				end
			end
		end
	end

	// Result side: random stalls, and on request one long hold-off.
	initial begin : result_sink
		int stall_left;
		int held;
		mini_ch.ready = 1'b0;
		stall_left    = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				mini_ch.ready <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
			end else if (stall_left > 0) begin
				mini_ch.ready <= 1'b0;
				stall_left--;
			end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
				mini_ch.ready <= (stall_left == 0);
			end else begin
				mini_ch.ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(logic idx, logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		apply_reg(idx, data);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic send_kmer(logic [KMER_W-1:0] v, logic eos);
		int gap;
		gap = source_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			kmer_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		kmer_ch.valid           <= 1'b1;
		kmer_ch.kmer_value      <= v;
		kmer_ch.end_of_sequence <= eos;
		do @(posedge clk); while (!kmer_ch.ready);
		kmers_sent++;
		if (eos) seqs_closed++;
	endtask

	task automatic send_random_sequences(int count);
		int left;
		int len;
		int w;
		left = count;
		while (left > 0) begin
			w = eff_len();
			if ($urandom_range(0, 9) < 2) len = $urandom_range(1, w);
			else len = $urandom_range(w, 3 * w + 4);
			if (len > left) len = left;
			for (int k = 0; k < len; k++) send_kmer(pick_kmer(), k == len - 1);
			left -= len;
		end
	endtask

	// The block may still be scanning after its last transfer, hence the settle time.
	task automatic wait_results_drained();
		kmer_ch.valid <= 1'b0;
		while (expected_minis.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic test_directed();
		write_reg(REG_WINDOW_LENGTH, 32'd4);
		write_reg(REG_SEQUENCE_NUMBER, 32'hFFFF_FFFF);
		send_kmer(64'd9, 1'b0);
		send_kmer(64'd8, 1'b1);
		send_kmer(64'd7, 1'b0);
		send_kmer(64'd7, 1'b0);
		send_kmer(64'd2, 1'b0);
		send_kmer(64'd5, 1'b1);
		send_kmer(ALL_ONES, 1'b0);
		send_kmer(64'd40, 1'b0);
		send_kmer(64'd40, 1'b0);
		send_kmer(64'd50, 1'b0);
		send_kmer(64'd40, 1'b0);
		for (int k = 0; k < 4; k++) send_kmer(64'd60, 1'b0);
		send_kmer(64'd0, 1'b0);
		send_kmer(64'd0, 1'b0);
		send_kmer(ALL_ONES, 1'b0);
		send_kmer(64'd90, 1'b1);
		wait_results_drained();
	endtask

	task automatic test_window_lengths();
		logic [APB_DW-1:0] len_words [5] = '{32'd1, 32'd16, 32'd0, 32'd31, 32'hFFFF_FFE6};
		foreach (len_words[p]) begin
			write_reg(REG_WINDOW_LENGTH, len_words[p]);
			write_reg(REG_SEQUENCE_NUMBER, (p == 0) ? 32'h0 : $urandom());
			send_random_sequences(28);
			send_kmer(pick_kmer(), 1'b0);
			send_kmer(pick_kmer(), 1'b0);
			wait_results_drained();
		end
	endtask

	task automatic test_backpressure();
		source_gaps = 1'b0;
		sink_stalls = 1'b0;
		write_reg(REG_WINDOW_LENGTH, 32'd3);
		write_reg(REG_SEQUENCE_NUMBER, $urandom());
		hold_request = 1'b1;
		send_random_sequences(40);
		wait_results_drained();
	endtask

	task automatic test_random_mix();
		for (int p = 0; p < 8; p++) begin
			source_gaps = ($urandom_range(0, 3) != 0);
			sink_stalls = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 4) == 0)
				write_reg(REG_WINDOW_LENGTH, $urandom_range(0, 31));
			else
				write_reg(REG_WINDOW_LENGTH, $urandom_range(1, WIN_DEPTH));
			write_reg(REG_SEQUENCE_NUMBER, $urandom());
			send_random_sequences(15);
			if ($urandom_range(0, 1) != 0) begin
				kmer_ch.valid <= 1'b0;
				while (expected_minis.size() != 0) @(posedge clk);
			end
			send_random_sequences(15);
			wait_results_drained();
		end
	endtask

	initial begin
		arst_n                  = 1'b0;
		psel                    = 1'b0;
		penable                 = 1'b0;
		pwrite                  = 1'b0;
		paddr                   = '0;
		pwdata                  = '0;
		kmer_ch.valid           = 1'b0;
		kmer_ch.kmer_value      = '0;
		kmer_ch.end_of_sequence = 1'b0;
		wlen_reg                = WLEN_RESET;
		seq_reg                 = '0;
		clear_sequence_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_window_lengths();
		test_backpressure();
		test_random_mix();
		wait_results_drained();

		$display("Streamed %0d k-mers in %0d closed sequences, checked %0d minimizers.",
			kmers_sent, seqs_closed, minis_checked);
		$display("Window lengths 0 to 31, long output hold-off and drained pauses included.");
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin : watchdog
		#15ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
